// ===== src/smpm_pkg.sv =====
// Shared types, register codes and reset values for the smoothed pan mixer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package smpm_pkg;

    localparam int NUM_PARTS  = 4;
    localparam int PART_W     = 2;
    localparam int SAMPLE_W   = 24;
    localparam int LANE_W     = 16;
    localparam int PAN_GAIN_W = 15;
    localparam int COEF_W     = 16;
    localparam int REG_W      = 64;
    localparam int CFG_IDX_W  = 3;

    typedef logic [PART_W-1:0]            part_t;
    typedef logic signed [SAMPLE_W-1:0]   sample_t;
    typedef logic [LANE_W-1:0]            lane_t;
    typedef logic [PAN_GAIN_W-1:0]        pan_gain_t;
    typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;

    localparam cfg_idx_t CFG_LEVEL_TARGETS  = 3'd0;
    localparam cfg_idx_t CFG_PAN_TARGETS    = 3'd1;
    localparam cfg_idx_t CFG_DELAY_SENDS    = 3'd2;
    localparam cfg_idx_t CFG_REVERB_SENDS   = 3'd3;
    localparam cfg_idx_t CFG_SMOOTH_COEF    = 3'd4;

    localparam part_t FIRST_PART = 2'd0;
    localparam part_t LAST_PART  = 2'd3;

    localparam logic [REG_W-1:0]  LEVEL_TARGETS_RST = 64'h4000_4000_4000_4000;
    localparam logic [REG_W-1:0]  PAN_TARGETS_RST   = 64'h0;
    localparam logic [REG_W-1:0]  DELAY_SENDS_RST   = 64'h0;
    localparam logic [REG_W-1:0]  REVERB_SENDS_RST  = 64'h0;
    localparam logic [COEF_W-1:0] SMOOTH_COEF_RST   = 16'd655;

    // one smoothed level / pan pair per part
    typedef struct packed {
        logic [LANE_W-1:0]        level;
        logic signed [LANE_W-1:0] pan;
    } smooth_entry_t;

    localparam smooth_entry_t SMOOTH_ENTRY_RST = '{level: 16'h4000, pan: 16'sh0000};

    // tag that travels down the pipeline with each part
    typedef struct packed {
        logic  valid;
        part_t part;
    } stage_ctl_t;

    typedef struct packed {
        sample_t dry_left;
        sample_t dry_right;
        sample_t delay_left;
        sample_t delay_right;
        sample_t reverb_left;
        sample_t reverb_right;
    } mix_out_t;

    function automatic lane_t get_lane(input logic [REG_W-1:0] r, input part_t p);
        return r[{p, 4'b0000} +: LANE_W];
    endfunction

endpackage

`default_nettype wire

// ===== src/smpm_state_ram.sv =====
// Smoothed level and pan store, one entry per part, registered read.
// Entries never written read back as the reset values. Uses smpm_pkg.
`default_nettype none

module smpm_state_ram (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  smpm_pkg::part_t         rd_addr,
    output smpm_pkg::smooth_entry_t rd_data,
    input  wire                     wr_en,
    input  smpm_pkg::part_t         wr_addr,
    input  smpm_pkg::smooth_entry_t wr_data
);

    smpm_pkg::smooth_entry_t        mem [smpm_pkg::NUM_PARTS];
    smpm_pkg::smooth_entry_t        rd_data_reg;
    logic [smpm_pkg::NUM_PARTS-1:0] valid_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : smpm_pkg::SMOOTH_ENTRY_RST;

endmodule

`default_nettype wire

// ===== src/smpm_pan_rom.sv =====
// Equal-power pan gain lookup: quarter-wave sqrt2*sin table in Q1.14,
// built at elaboration, two registered reads (left and right). Uses smpm_pkg.
`default_nettype none

module smpm_pan_rom #(
    parameter int DEPTH = 256
) (
    input  wire                       aclk,
    input  wire signed [15:0]         pan,
    output smpm_pkg::pan_gain_t       gain_left,
    output smpm_pkg::pan_gain_t       gain_right
);

    localparam int ADDR_W = $clog2(DEPTH + 1);
    localparam int PROD_W = 16 + ADDR_W;

    localparam logic [63:0] Q30_ONE    = 64'd1073741824;
    localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
    localparam logic [63:0] SQRT2_Q30  = 64'd1518500250;
    localparam logic [63:0] DEPTH_W64  = 64'(DEPTH);

    typedef smpm_pkg::pan_gain_t rom_t [DEPTH + 1];

    // sin series to x^11 in Q30, then scaled by sqrt2 and rounded to Q1.14
    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        for (int k = 0; k <= DEPTH; k++) begin
            x  = (64'(k) * HALFPI_Q30) / DEPTH_W64;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            e  = (s * SQRT2_Q30 + (64'd1 << 45)) >> 46;
            r[k] = e[smpm_pkg::PAN_GAIN_W-1:0];
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [15:0]       pan_offset;
    logic [PROD_W-1:0] idx_prod;
    logic [ADDR_W-1:0] addr_right;
    logic [ADDR_W-1:0] addr_left;

    smpm_pkg::pan_gain_t gain_left_reg;
    smpm_pkg::pan_gain_t gain_right_reg;

    // pan + 32768 mod 2^16 is the pan with its sign bit flipped
    assign pan_offset = {~pan[15], pan[14:0]};
    assign idx_prod   = PROD_W'(pan_offset) * PROD_W'(DEPTH);
    assign addr_right = idx_prod[16 +: ADDR_W];
    assign addr_left  = ADDR_W'(DEPTH) - addr_right;

    always_ff @(posedge aclk) begin
        gain_right_reg <= ROM[addr_right];
        gain_left_reg  <= ROM[addr_left];
    end

    assign gain_left  = gain_left_reg;
    assign gain_right = gain_right_reg;

endmodule

`default_nettype wire

// ===== src/smpm_mac.sv =====
// Per-part scaling, send gain products and six-way accumulation, saturated on output.
// Two registered stages (F, G) plus the stage H accumulators; uses smpm_pkg.
`default_nettype none

module smpm_mac (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  smpm_pkg::stage_ctl_t        ctl_in,
    input  smpm_pkg::lane_t             level,
    input  smpm_pkg::pan_gain_t         gain_left,
    input  smpm_pkg::pan_gain_t         gain_right,
    input  smpm_pkg::sample_t           sample_left,
    input  smpm_pkg::sample_t           sample_right,
    input  wire [smpm_pkg::REG_W-1:0]   delay_gains,
    input  wire [smpm_pkg::REG_W-1:0]   reverb_gains,
    output logic                        done,
    output smpm_pkg::mix_out_t          result
);

    localparam int NUM_SUMS = 6;
    localparam int ACC_W    = 32;

    localparam logic signed [56:0]      X_HALF    = 57'sd134217728;
    localparam logic signed [44:0]      TERM_HALF = 45'sd8192;
    localparam logic signed [ACC_W-1:0] SAT_POS   = 32'sd8388607;
    localparam logic signed [ACC_W-1:0] SAT_NEG   = -32'sd8388608;

    function automatic smpm_pkg::sample_t sat24(input logic signed [ACC_W-1:0] v);
        if (v > SAT_POS) begin
            return 24'sh7FFFFF;
        end else if (v < SAT_NEG) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    // stage F: sample * level
    smpm_pkg::stage_ctl_t f_ctl_reg;
    logic signed [40:0]   f_ml_reg;
    logic signed [40:0]   f_mr_reg;
    smpm_pkg::pan_gain_t  f_gl_reg;
    smpm_pkg::pan_gain_t  f_gr_reg;
    logic signed [40:0]   ml;
    logic signed [40:0]   mr;

    // stage G: rounded panned part
    smpm_pkg::stage_ctl_t g_ctl_reg;
    logic signed [27:0]   g_xl_reg;
    logic signed [27:0]   g_xr_reg;
    logic signed [56:0]   pl;
    logic signed [56:0]   pr;

    // stage H: accumulators
    logic signed [44:0]      send_prod [4];
    logic signed [ACC_W-1:0] term [NUM_SUMS];
    logic signed [ACC_W-1:0] acc_reg [NUM_SUMS];
    logic                    done_reg;
    smpm_pkg::lane_t         ds;
    smpm_pkg::lane_t         rs;

    assign ml = sample_left  * $signed({1'b0, level});
    assign mr = sample_right * $signed({1'b0, level});

    always_ff @(posedge aclk) begin
        f_ml_reg <= ml;
        f_mr_reg <= mr;
        f_gl_reg <= gain_left;
        f_gr_reg <= gain_right;
    end

    assign pl = f_ml_reg * $signed({1'b0, f_gl_reg}) + X_HALF;
    assign pr = f_mr_reg * $signed({1'b0, f_gr_reg}) + X_HALF;

    always_ff @(posedge aclk) begin
        g_xl_reg <= pl[55:28];
        g_xr_reg <= pr[55:28];
    end

    assign ds = smpm_pkg::get_lane(delay_gains,  g_ctl_reg.part);
    assign rs = smpm_pkg::get_lane(reverb_gains, g_ctl_reg.part);

    assign send_prod[0] = g_xl_reg * $signed({1'b0, ds}) + TERM_HALF;
    assign send_prod[1] = g_xr_reg * $signed({1'b0, ds}) + TERM_HALF;
    assign send_prod[2] = g_xl_reg * $signed({1'b0, rs}) + TERM_HALF;
    assign send_prod[3] = g_xr_reg * $signed({1'b0, rs}) + TERM_HALF;

    always_comb begin
        term[0] = {{4{g_xl_reg[27]}}, g_xl_reg};
        term[1] = {{4{g_xr_reg[27]}}, g_xr_reg};
        for (int i = 0; i < 4; i++) begin
            term[i + 2] = {{2{send_prod[i][43]}}, send_prod[i][43:14]};
        end
    end

    always_ff @(posedge aclk) begin
        if (g_ctl_reg.valid) begin
            for (int i = 0; i < NUM_SUMS; i++) begin
                acc_reg[i] <= ((g_ctl_reg.part == smpm_pkg::FIRST_PART) ? '0 : acc_reg[i])
                              + term[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_ctl_reg <= '0;
            g_ctl_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            f_ctl_reg <= ctl_in;
            g_ctl_reg <= f_ctl_reg;
            done_reg  <= g_ctl_reg.valid && (g_ctl_reg.part == smpm_pkg::LAST_PART);
        end
    end

    assign done                = done_reg;
    assign result.dry_left     = sat24(acc_reg[0]);
    assign result.dry_right    = sat24(acc_reg[1]);
    assign result.delay_left   = sat24(acc_reg[2]);
    assign result.delay_right  = sat24(acc_reg[3]);
    assign result.reverb_left  = sat24(acc_reg[4]);
    assign result.reverb_right = sat24(acc_reg[5]);

endmodule

`default_nettype wire

// ===== src/smoothed_pan_mixer_with_sends_core.sv =====
// Four-part stereo pan mixer with smoothed level/pan and delay/reverb sends.
// Top level: config registers, sequencer, smoothing stage; uses smpm_pkg,
// smpm_state_ram, smpm_pan_rom and smpm_mac.
//
// Usage:
//   s_* is the input channel: one beat carries a stereo sample for each of
//   the four parts plus s_block_start, which restarts the control interval.
//   m_* is the result channel: one beat per input beat with the dry pair and
//   the delay and reverb send pairs, saturated Q1.23.
//   cfg_we/cfg_index/cfg_data write the five registers, one per cycle.
// Timing:
//   The four parts go through the pipeline one per cycle: state RAM read,
//   smoothing step and write-back, pan ROM read, two multiply stages and
//   the accumulators. s_ready returns high as the result enters the output
//   register, so a new input beat is taken only after the last one is mixed.
// Reset:
//   Registers return to their defaults, the control interval count clears,
//   and the smoothed state reads as its defaults until first written.
// Stall:
//   A result waits in the output register while the next beat is accepted
//   and mixed; s_ready then stays low until the output register frees.
`default_nettype none

module smoothed_pan_mixer_with_sends_core #(
    parameter int CONTROL_INTERVAL = 32,
    parameter int PAN_TABLE_DEPTH  = 256
) (
    input  wire                         aclk,
    input  wire                         aresetn,

    input  wire                         s_valid,
    output logic                        s_ready,
    input  smpm_pkg::sample_t           s_part0_left,
    input  smpm_pkg::sample_t           s_part0_right,
    input  smpm_pkg::sample_t           s_part1_left,
    input  smpm_pkg::sample_t           s_part1_right,
    input  smpm_pkg::sample_t           s_part2_left,
    input  smpm_pkg::sample_t           s_part2_right,
    input  smpm_pkg::sample_t           s_part3_left,
    input  smpm_pkg::sample_t           s_part3_right,
    input  wire                         s_block_start,

    output logic                        m_valid,
    input  wire                         m_ready,
    output smpm_pkg::sample_t           m_dry_left,
    output smpm_pkg::sample_t           m_dry_right,
    output smpm_pkg::sample_t           m_delay_send_left,
    output smpm_pkg::sample_t           m_delay_send_right,
    output smpm_pkg::sample_t           m_reverb_send_left,
    output smpm_pkg::sample_t           m_reverb_send_right,

    input  wire                         cfg_we,
    input  smpm_pkg::cfg_idx_t          cfg_index,
    input  wire [smpm_pkg::REG_W-1:0]   cfg_data
);

    localparam int CNT_W = (CONTROL_INTERVAL > 1) ? $clog2(CONTROL_INTERVAL) : 1;

    // configuration
    logic [smpm_pkg::REG_W-1:0]  level_targets_reg;
    logic [smpm_pkg::REG_W-1:0]  pan_targets_reg;
    logic [smpm_pkg::REG_W-1:0]  delay_sends_reg;
    logic [smpm_pkg::REG_W-1:0]  reverb_sends_reg;
    logic [smpm_pkg::COEF_W-1:0] smooth_coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_targets_reg <= smpm_pkg::LEVEL_TARGETS_RST;
            pan_targets_reg   <= smpm_pkg::PAN_TARGETS_RST;
            delay_sends_reg   <= smpm_pkg::DELAY_SENDS_RST;
            reverb_sends_reg  <= smpm_pkg::REVERB_SENDS_RST;
            smooth_coef_reg   <= smpm_pkg::SMOOTH_COEF_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                smpm_pkg::CFG_LEVEL_TARGETS: level_targets_reg <= cfg_data;
                smpm_pkg::CFG_PAN_TARGETS:   pan_targets_reg   <= cfg_data;
                smpm_pkg::CFG_DELAY_SENDS:   delay_sends_reg   <= cfg_data;
                smpm_pkg::CFG_REVERB_SENDS:  reverb_sends_reg  <= cfg_data;
                smpm_pkg::CFG_SMOOTH_COEF:   smooth_coef_reg   <= cfg_data[smpm_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // input beat capture and control interval
    logic                 busy_reg;
    logic                 pending_reg;
    logic                 tick_reg;
    logic                 tick_next;
    logic [CNT_W-1:0]     interval_reg;
    logic [CNT_W-1:0]     interval_next;
    logic [CNT_W-1:0]     interval_base;
    logic [CNT_W:0]       interval_inc;
    logic                 in_fire;
    logic                 out_xfer;

    smpm_pkg::sample_t    in_left_reg  [smpm_pkg::NUM_PARTS];
    smpm_pkg::sample_t    in_right_reg [smpm_pkg::NUM_PARTS];

    assign s_ready  = !busy_reg;
    assign in_fire  = s_valid && s_ready;
    assign out_xfer = pending_reg && (!m_valid || m_ready);

    assign interval_base = s_block_start ? '0 : interval_reg;
    assign tick_next     = (interval_base == '0);
    assign interval_inc  = {1'b0, interval_base} + 1'b1;
    assign interval_next = (interval_inc >= (CNT_W + 1)'(CONTROL_INTERVAL)) ?
                           '0 : interval_inc[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_left_reg[0]  <= s_part0_left;
            in_right_reg[0] <= s_part0_right;
            in_left_reg[1]  <= s_part1_left;
            in_right_reg[1] <= s_part1_right;
            in_left_reg[2]  <= s_part2_left;
            in_right_reg[2] <= s_part2_right;
            in_left_reg[3]  <= s_part3_left;
            in_right_reg[3] <= s_part3_right;
            tick_reg        <= tick_next;
        end
    end

    // sequencer and pipeline tags
    smpm_pkg::stage_ctl_t issue_reg;
    smpm_pkg::stage_ctl_t b_ctl_reg;
    smpm_pkg::stage_ctl_t c_ctl_reg;
    smpm_pkg::stage_ctl_t d_ctl_reg;
    smpm_pkg::stage_ctl_t e_ctl_reg;
    logic                 mac_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pending_reg  <= 1'b0;
            interval_reg <= '0;
            issue_reg    <= '0;
            b_ctl_reg    <= '0;
            c_ctl_reg    <= '0;
            d_ctl_reg    <= '0;
            e_ctl_reg    <= '0;
        end else begin
            if (in_fire) begin
                busy_reg     <= 1'b1;
                interval_reg <= interval_next;
                issue_reg    <= '{valid: 1'b1, part: smpm_pkg::FIRST_PART};
            end else if (issue_reg.valid) begin
                if (issue_reg.part == smpm_pkg::LAST_PART) begin
                    issue_reg.valid <= 1'b0;
                end else begin
                    issue_reg.part <= issue_reg.part + 1'b1;
                end
            end
            if (mac_done) begin
                pending_reg <= 1'b1;
            end
            if (out_xfer) begin
                pending_reg <= 1'b0;
                busy_reg    <= 1'b0;
            end
            b_ctl_reg <= issue_reg;
            c_ctl_reg <= b_ctl_reg;
            d_ctl_reg <= c_ctl_reg;
            e_ctl_reg <= d_ctl_reg;
        end
    end

    // stage B: state read data, distance to target
    smpm_pkg::smooth_entry_t ram_rd;
    smpm_pkg::smooth_entry_t ram_wr;
    smpm_pkg::lane_t         tgt_level;
    smpm_pkg::lane_t         tgt_pan;

    logic [15:0]             c_level_reg;
    logic signed [15:0]      c_pan_reg;
    logic signed [16:0]      c_dlevel_reg;
    logic signed [16:0]      c_dpan_reg;

    smpm_state_ram u_state_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (issue_reg.part),
        .rd_data (ram_rd),
        .wr_en   (c_ctl_reg.valid),
        .wr_addr (c_ctl_reg.part),
        .wr_data (ram_wr)
    );

    assign tgt_level = smpm_pkg::get_lane(level_targets_reg, b_ctl_reg.part);
    assign tgt_pan   = smpm_pkg::get_lane(pan_targets_reg,   b_ctl_reg.part);

    always_ff @(posedge aclk) begin
        c_level_reg  <= ram_rd.level;
        c_pan_reg    <= ram_rd.pan;
        c_dlevel_reg <= $signed({1'b0, tgt_level}) - $signed({1'b0, ram_rd.level});
        c_dpan_reg   <= $signed({tgt_pan[15], tgt_pan}) - $signed({ram_rd.pan[15], ram_rd.pan});
    end

    // stage C: one-pole step on a control tick, written back to the state RAM
    logic signed [16:0] coef_s;
    logic signed [33:0] prod_level;
    logic signed [33:0] prod_pan;
    logic signed [16:0] sum_level;
    logic signed [16:0] sum_pan;

    logic [15:0]        d_level_reg;
    logic signed [15:0] d_pan_reg;

    assign coef_s     = $signed({1'b0, smooth_coef_reg});
    assign prod_level = c_dlevel_reg * coef_s;
    assign prod_pan   = c_dpan_reg * coef_s;
    // floor of product / 2^16, never past the target
    assign sum_level  = $signed({1'b0, c_level_reg}) + prod_level[32:16];
    assign sum_pan    = $signed({c_pan_reg[15], c_pan_reg}) + prod_pan[32:16];

    assign ram_wr.level = tick_reg ? sum_level[15:0] : c_level_reg;
    assign ram_wr.pan   = tick_reg ? sum_pan[15:0]   : c_pan_reg;

    always_ff @(posedge aclk) begin
        d_level_reg <= ram_wr.level;
        d_pan_reg   <= ram_wr.pan;
    end

    // stage D: pan gain lookup, result at stage E
    smpm_pkg::pan_gain_t gain_left;
    smpm_pkg::pan_gain_t gain_right;
    smpm_pkg::lane_t     e_level_reg;

    smpm_pan_rom #(
        .DEPTH (PAN_TABLE_DEPTH)
    ) u_pan_rom (
        .aclk       (aclk),
        .pan        (d_pan_reg),
        .gain_left  (gain_left),
        .gain_right (gain_right)
    );

    always_ff @(posedge aclk) begin
        e_level_reg <= d_level_reg;
    end

    // stage E onwards: scaling, sends and accumulation
    smpm_pkg::mix_out_t mac_result;

    smpm_mac u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl_in       (e_ctl_reg),
        .level        (e_level_reg),
        .gain_left    (gain_left),
        .gain_right   (gain_right),
        .sample_left  (in_left_reg[e_ctl_reg.part]),
        .sample_right (in_right_reg[e_ctl_reg.part]),
        .delay_gains  (delay_sends_reg),
        .reverb_gains (reverb_sends_reg),
        .done         (mac_done),
        .result       (mac_result)
    );

    // output register
    logic               m_valid_reg;
    smpm_pkg::mix_out_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_xfer) begin
            out_reg <= mac_result;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_dry_left          = out_reg.dry_left;
    assign m_dry_right         = out_reg.dry_right;
    assign m_delay_send_left   = out_reg.delay_left;
    assign m_delay_send_right  = out_reg.delay_right;
    assign m_reverb_send_left  = out_reg.reverb_left;
    assign m_reverb_send_right = out_reg.reverb_right;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for smoothed_pan_mixer_with_sends_core: directed and random
// four-part frames, each mix predicted and compared beat by beat.
// Depends on smpm_pkg and the core RTL only.
module tb;
    import smpm_pkg::*;

    localparam int TICK_SPAN = 32;
    localparam int PAN_DEPTH = 256;
    localparam int DRAIN_PAD = 20;
    localparam int ERR_SHOWN = 10;
    localparam int SEG_BEATS = 40;
    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
    localparam longint unsigned SQRT2_Q30  = 64'd1518500250;
    localparam sample_t FULL_POS = 24'sh7F_FFFF;
    localparam sample_t FULL_NEG = 24'sh80_0000;

    typedef struct packed {
        logic            block_start;
        sample_t [7:0]   smp;           // part p: left at 2p, right at 2p+1
    } frame_t;

    class pan_mix_checker;
        logic [REG_W-1:0]  level_tgt, pan_tgt, dly_gain, rvb_gain;
        logic [COEF_W-1:0] coef;
        logic [LANE_W-1:0] level_now [NUM_PARTS];
        int                pan_now [NUM_PARTS];
        int                tick_cnt;
        longint            gain_rom [PAN_DEPTH+1];
        mix_out_t          pending_mixes [$];
        int                mismatches;

        function new();
            for (int k = 0; k <= PAN_DEPTH; k++)
                gain_rom[k] = sine_gain(k);
            level_tgt = LEVEL_TARGETS_RST;
            pan_tgt   = PAN_TARGETS_RST;
            dly_gain  = DELAY_SENDS_RST;
            rvb_gain  = REVERB_SENDS_RST;
            coef      = SMOOTH_COEF_RST;
            for (int p = 0; p < NUM_PARTS; p++) begin
                level_now[p] = SMOOTH_ENTRY_RST.level;
                pan_now[p]   = $signed(SMOOTH_ENTRY_RST.pan);
            end
            tick_cnt   = 0;
            mismatches = 0;
        endfunction

        // sqrt2 * sin(k*pi/2D) in Q1.14 via an odd series in Q30
        function longint sine_gain(int k);
            longint unsigned x, x2, t, s;
            x  = k;
            x  = (x * HALFPI_Q30) / PAN_DEPTH;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) >> 30) / 110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            return longint'((s * SQRT2_Q30 + (Q30_ONE << 15)) >> 46);
        endfunction

        function int glide(int cur, int tgt);
            longint d;
            d = longint'(tgt) - longint'(cur);
            return cur + int'((d * longint'(coef)) >>> 16);
        endfunction

        function longint rnd(longint v, int n);
            return (v + (longint'(1) << (n - 1))) >>> n;
        endfunction

        function sample_t clip(longint v);
            if (v > longint'(FULL_POS)) return FULL_POS;
            if (v < longint'(FULL_NEG)) return FULL_NEG;
            return sample_t'(v);
        endfunction

        function void set_reg(cfg_idx_t idx, logic [REG_W-1:0] v);
            case (idx)
                CFG_LEVEL_TARGETS: level_tgt = v;
                CFG_PAN_TARGETS:   pan_tgt   = v;
                CFG_DELAY_SENDS:   dly_gain  = v;
                CFG_REVERB_SENDS:  rvb_gain  = v;
                CFG_SMOOTH_COEF:   coef      = v[COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_samples(frame_t f);
            longint            acc [6];
            longint            xl, xr, lv, gl, gr, ds, rs;
            int unsigned       idx;
            logic [LANE_W-1:0] u;
            mix_out_t          want;
            foreach (acc[j]) acc[j] = 0;
            if (f.block_start) tick_cnt = 0;
            // control tick: state moves before this frame is mixed
            if (tick_cnt == 0) begin
                for (int p = 0; p < NUM_PARTS; p++) begin
                    level_now[p] = LANE_W'(glide(level_now[p], level_tgt[16*p +: 16]));
                    pan_now[p]   = glide(pan_now[p], $signed(pan_tgt[16*p +: 16]));
                end
            end
            tick_cnt++;
            if (tick_cnt >= TICK_SPAN) tick_cnt = 0;
            for (int p = 0; p < NUM_PARTS; p++) begin
                u   = LANE_W'(pan_now[p] + 32768);
                idx = (int'(u) * PAN_DEPTH) >> 16;
                gr  = gain_rom[idx];
                gl  = gain_rom[PAN_DEPTH - idx];
                lv  = level_now[p];
                ds  = dly_gain[16*p +: 16];
                rs  = rvb_gain[16*p +: 16];
                xl  = rnd(longint'($signed(f.smp[2*p])) * lv * gl, 28);
                xr  = rnd(longint'($signed(f.smp[2*p+1])) * lv * gr, 28);
                acc[0] += xl;
                acc[1] += xr;
                acc[2] += rnd(xl * ds, 14);
                acc[3] += rnd(xr * ds, 14);
                acc[4] += rnd(xl * rs, 14);
                acc[5] += rnd(xr * rs, 14);
            end
            want.dry_left     = clip(acc[0]);
            want.dry_right    = clip(acc[1]);
            want.delay_left   = clip(acc[2]);
            want.delay_right  = clip(acc[3]);
            want.reverb_left  = clip(acc[4]);
            want.reverb_right = clip(acc[5]);
            pending_mixes.push_back(want);
        endfunction

        function void note_fault(string what, sample_t want, sample_t got);
            mismatches++;
            if (mismatches <= ERR_SHOWN)
                $display("mix fault, %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void check_mix(mix_out_t got);
            mix_out_t want;
            string    field_name [6] = '{"dry_left", "dry_right", "delay_send_left",
                                         "delay_send_right", "reverb_send_left",
                                         "reverb_send_right"};
            if (pending_mixes.size() == 0) begin
                note_fault("beat with nothing pending (dry_left)", '0, got.dry_left);
                return;
            end
            want = pending_mixes.pop_front();
            // dry_left sits in the top lane of the packed struct
            for (int j = 0; j < 6; j++)
                if (want[(5-j)*SAMPLE_W +: SAMPLE_W] !== got[(5-j)*SAMPLE_W +: SAMPLE_W])
                    note_fault(field_name[j], want[(5-j)*SAMPLE_W +: SAMPLE_W],
                               got[(5-j)*SAMPLE_W +: SAMPLE_W]);
        endfunction
    endclass

    logic             aclk, aresetn;
    logic             s_valid, s_ready, s_block_start;
    sample_t          s_part0_left, s_part0_right, s_part1_left, s_part1_right;
    sample_t          s_part2_left, s_part2_right, s_part3_left, s_part3_right;
    logic             m_valid, m_ready;
    sample_t          m_dry_left, m_dry_right, m_delay_send_left, m_delay_send_right;
    sample_t          m_reverb_send_left, m_reverb_send_right;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [REG_W-1:0] cfg_data;

    pan_mix_checker   scoreboard;
    int               tx_idle_pct;
    int               rx_stall_pct;

    smoothed_pan_mixer_with_sends_core #(
        .CONTROL_INTERVAL(TICK_SPAN),
        .PAN_TABLE_DEPTH(PAN_DEPTH)
    ) dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            scoreboard.check_mix({m_dry_left, m_dry_right, m_delay_send_left,
                                  m_delay_send_right, m_reverb_send_left,
                                  m_reverb_send_right});
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [REG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        scoreboard.set_reg(idx, v);
    endtask

    task automatic load_setting(input logic [REG_W-1:0] lv, pn, dl, rv, cf);
        write_reg(CFG_LEVEL_TARGETS, lv);
        write_reg(CFG_PAN_TARGETS, pn);
        write_reg(CFG_DELAY_SENDS, dl);
        write_reg(CFG_REVERB_SENDS, rv);
        write_reg(CFG_SMOOTH_COEF, cf);
        // indices past the last register must leave everything alone
        write_reg(cfg_idx_t'(CFG_SMOOTH_COEF + 1 + $urandom_range(2)), {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    // drop valid and wait until every mix is back and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (scoreboard.pending_mixes.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic send_frame(input frame_t f);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_block_start <= f.block_start;
        s_part0_left  <= f.smp[0];
        s_part0_right <= f.smp[1];
        s_part1_left  <= f.smp[2];
        s_part1_right <= f.smp[3];
        s_part2_left  <= f.smp[4];
        s_part2_right <= f.smp[5];
        s_part3_left  <= f.smp[6];
        s_part3_right <= f.smp[7];
        do @(posedge aclk); while (!s_ready);
        scoreboard.take_samples(f);
    endtask

    function automatic frame_t flat_frame(logic start, sample_t v);
        frame_t f;
        f.block_start = start;
        for (int i = 0; i < 8; i++) f.smp[i] = v;
        return f;
    endfunction

    function automatic frame_t pick_frame(logic start);
        frame_t f;
        f.block_start = start;
        for (int i = 0; i < 8; i++)
            case ($urandom_range(9))
                0:       f.smp[i] = FULL_POS;
                1:       f.smp[i] = FULL_NEG;
                2:       f.smp[i] = sample_t'($signed($urandom_range(511)) - 256);
                default: f.smp[i] = sample_t'($urandom);
            endcase
        return f;
    endfunction

    function automatic logic [REG_W-1:0] pick_lanes();
        logic [REG_W-1:0] r;
        for (int p = 0; p < NUM_PARTS; p++)
            case ($urandom_range(7))
                0:       r[16*p +: 16] = 16'h0000;
                1:       r[16*p +: 16] = 16'hFFFF;
                2:       r[16*p +: 16] = 16'h8000;
                3:       r[16*p +: 16] = 16'h7FFF;
                default: r[16*p +: 16] = 16'($urandom);
            endcase
        return r;
    endfunction

    function automatic logic [REG_W-1:0] pick_coef();
        logic [REG_W-1:0] r;
        r = {$urandom, $urandom};       // junk above the coefficient lane
        case ($urandom_range(5))
            0:       r[COEF_W-1:0] = '0;
            1:       r[COEF_W-1:0] = '1;
            2:       r[COEF_W-1:0] = SMOOTH_COEF_RST;
            default: r[COEF_W-1:0] = COEF_W'($urandom);
        endcase
        return r;
    endfunction

    initial begin
        frame_t f;
        int     len, n, i;
        scoreboard    = new();
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_block_start <= 1'b0;
        s_part0_left  <= '0;
        s_part0_right <= '0;
        s_part1_left  <= '0;
        s_part1_right <= '0;
        s_part2_left  <= '0;
        s_part2_right <= '0;
        s_part3_left  <= '0;
        s_part3_right <= '0;
        m_ready       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_LEVEL_TARGETS;
        cfg_data      <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: unity level, centre pan, sends off
        send_frame(flat_frame(1'b1, FULL_POS));
        send_frame(flat_frame(1'b0, FULL_NEG));
        send_frame(flat_frame(1'b0, '0));
        settle();

        // hard left, hard right, centre and just-left pans; full level and delay sends
        // so sums clip; near-unity coefficient snaps state on the first tick
        load_setting(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_0000_7FFF_8000,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'h4000_0001_8000_FFFF,
                     64'h5A5A_A5A5_3C3C_FFFF);
        send_frame(flat_frame(1'b1, FULL_POS));
        send_frame(flat_frame(1'b0, FULL_NEG));
        f = flat_frame(1'b0, FULL_POS);
        for (i = 1; i < 8; i += 2) f.smp[i] = FULL_NEG;
        send_frame(f);
        for (i = 0; i < 3; i++) send_frame(pick_frame(1'b0));
        settle();

        // zero coefficient: targets drop to zero but the state must hold
        load_setting('0, '0, '0, '0, {48'hFFFF_FFFF_FFFF, 16'h0000});
        send_frame(flat_frame(1'b1, FULL_POS));
        send_frame(pick_frame(1'b1));
        send_frame(pick_frame(1'b0));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 47; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 47; end
                default: begin tx_idle_pct = 9;  rx_stall_pct = 9;  end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                settle();
                load_setting(pick_lanes(), pick_lanes(), pick_lanes(), pick_lanes(),
                             pick_coef());
                n = 0;
                while (n < SEG_BEATS) begin
                    // blocks run past the tick interval; some lack their start mark
                    len = $urandom_range(72, 1);
                    for (i = 0; i < len && n < SEG_BEATS; i++) begin
                        send_frame(pick_frame(i == 0 && $urandom_range(7) != 0));
                        n++;
                    end
                end
            end
        end

        settle();
        if (scoreboard.mismatches == 0 && scoreboard.pending_mixes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== smoothed_pan_mixer_with_sends_core.f =====
src/smpm_pkg.sv
src/smpm_state_ram.sv
src/smpm_pan_rom.sv
src/smpm_mac.sv
src/smoothed_pan_mixer_with_sends_core.sv
sim/tb.sv
